// ----- rtl/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helpers for the integer to ASCII digit block.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_W        = 32;
    localparam int KIND_W         = 1;
    localparam int CHAR_W         = 7;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [KIND_W-1:0] KIND_DEC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_HEX = 1'b1;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'd48;  // '0'
    localparam logic [CHAR_W-1:0] ASCII_HEX_OFS = 7'd87;  // 'W' = 'a' - 10
    localparam logic [3:0]        DEC_MAX       = 4'd9;
    localparam logic [3:0]        DABBLE_LIMIT  = 4'd5;
    localparam logic [3:0]        DABBLE_ADD    = 4'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [KIND_W-1:0]  kind;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } digit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic one_left;
        logic out_free;
    } status_t;

    // Upper bound on decimal digits of an n-bit value (1233/4096 ~ log10(2)).
    function automatic int dec_digits(input int n);
        return ((n * 1233) >> 12) + 1;
    endfunction

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [CHAR_W-1:0] to_char(input logic [3:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        return (d <= DEC_MAX) ? (ASCII_ZERO + d_ext) : (ASCII_HEX_OFS + d_ext);
    endfunction

endpackage

// ----- rtl/itoa_ctrl.sv -----
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: load, binary to BCD conversion, leading zero skip, digit emit.
// ----------------------------------------------------------------------------
module itoa_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic [itoa_pkg::KIND_W-1:0]    kind,
    output logic                           item_ready,
    input  itoa_pkg::status_t              status,
    output itoa_pkg::cmd_t                 cmd
);

    itoa_pkg::state_t state_reg;
    itoa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itoa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if (kind == itoa_pkg::KIND_HEX)
                    begin
                        state_next = itoa_pkg::ST_SKIP;
                    end
                    else
                    begin
                        state_next = itoa_pkg::ST_CONVERT;
                    end
                end
            end
            itoa_pkg::ST_CONVERT:
            begin
                if (status.conv_done)
                begin
                    state_next = itoa_pkg::ST_SKIP;
                end
                else
                begin
                    cmd.dabble = 1'b1;
                end
            end
            itoa_pkg::ST_SKIP:
            begin
                if (status.top_zero && !status.one_left)
                begin
                    cmd.shift = 1'b1;
                end
                else
                begin
                    state_next = itoa_pkg::ST_EMIT;
                end
            end
            itoa_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.one_left)
                    begin
                        state_next = itoa_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/itoa_dp.sv -----
// ----------------------------------------------------------------------------
// itoa_dp
// Digit register with shift-add-3 BCD conversion, digit shifter and
// output register.
// ----------------------------------------------------------------------------
module itoa_dp #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  itoa_pkg::item_t     item,
    input  itoa_pkg::cmd_t      cmd,
    output itoa_pkg::status_t   status,
    output logic                digit_valid,
    input  logic                digit_ready,
    output itoa_pkg::digit_t    digit
);

    localparam int DEC_DIGITS = itoa_pkg::dec_digits(VALUE_BITS);
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int NDIG       = itoa_pkg::max_int(DEC_DIGITS, HEX_DIGITS);
    localparam int DW         = NDIG * 4;
    localparam int CNT_W      = $clog2(NDIG + 1);
    localparam int BCNT_W     = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [DW-1:0]         dig_reg, dig_next;
    logic [BCNT_W-1:0]     bits_reg, bits_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    itoa_pkg::digit_t      out_reg, out_next;

    logic [DW-1:0]         adj;
    logic [3:0]            top;
    logic [VALUE_BITS-1:0] val_in;

    assign val_in = VALUE_BITS'(item.value);
    assign top    = dig_reg[DW-1 -: 4];

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            adj[i*4 +: 4] = (dig_reg[i*4 +: 4] >= itoa_pkg::DABBLE_LIMIT)
                          ? dig_reg[i*4 +: 4] + itoa_pkg::DABBLE_ADD
                          : dig_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        bin_next       = bin_reg;
        dig_next       = dig_reg;
        bits_next      = bits_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && digit_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            cnt_next  = CNT_W'(NDIG);
            bits_next = BCNT_W'(VALUE_BITS);
            bin_next  = val_in;
            if (item.kind == itoa_pkg::KIND_HEX)
            begin
                dig_next = DW'(val_in);
            end
            else
            begin
                dig_next = '0;
            end
        end
        else if (cmd.dabble)
        begin
            {dig_next, bin_next} = {adj[DW-2:0], bin_reg, 1'b0};
            bits_next            = bits_reg - BCNT_W'(1);
        end
        else if (cmd.shift || cmd.emit)
        begin
            dig_next = {dig_reg[DW-5:0], 4'd0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cmd.emit)
            begin
                out_valid_next      = 1'b1;
                out_next.digit_char = itoa_pkg::to_char(top);
                out_next.last       = (cnt_reg == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            bits_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            bits_reg      <= bits_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        dig_reg <= dig_next;
        out_reg <= out_next;
    end

    assign status.conv_done = (bits_reg == '0);
    assign status.top_zero  = (top == 4'd0);
    assign status.one_left  = (cnt_reg == CNT_W'(1));
    assign status.out_free  = !out_valid_reg || digit_ready;

    assign digit_valid = out_valid_reg;
    assign digit       = out_reg;

endmodule

// ----- rtl/int_to_ascii_digits.sv -----
// Sequence per number: load, shift-add-3 conversion (decimal only, skipped for hex), leading
// zero positions skipped one by one, a turnaround into emit, then one digit per cycle unless the output stalls.
// One number at a time; the next is taken the cycle after the final digit is registered.
// Reset (rst_n, async, active low) returns the sequencer to idle and empties the output.
// ----------------------------------------------------------------------------
// int_to_ascii_digits
// Converts an unsigned value to ASCII digits, decimal or lowercase hex,
// most significant first, one transaction per digit.
// ----------------------------------------------------------------------------
module int_to_ascii_digits #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  itoa_pkg::item_t   item,
    output logic              digit_valid,
    input  logic              digit_ready,
    output itoa_pkg::digit_t  digit
);

    itoa_pkg::cmd_t    cmd;
    itoa_pkg::status_t status;

    itoa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .kind       (item.kind),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    itoa_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cmd         (cmd),
        .status      (status),
        .digit_valid (digit_valid),
        .digit_ready (digit_ready),
        .digit       (digit)
    );

endmodule

// ----- tb/int_to_ascii_digits_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int_to_ascii_digits_test
// Drives numbers into int_to_ascii_digits and checks every digit transaction
// against table text or a built-in digit predictor: a directed table of edge
// values, then random numbers under three sender/receiver pacing phases.
// ----------------------------------------------------------------------------
module int_to_ascii_digits_test;

    localparam int QUIET_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 60;
    localparam int PHASE_ITEMS  = 140;
    localparam logic [itoa_pkg::CHAR_W-1:0] CHAR_LOWER_A = 7'h61;

    typedef struct {
        logic [itoa_pkg::VALUE_W-1:0] value;
        logic [itoa_pkg::KIND_W-1:0]  kind;
        string                        text;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    itoa_pkg::item_t    item_bus;
    logic               digit_valid;
    logic               digit_ready;
    itoa_pkg::digit_t   digit_bus;

    itoa_pkg::digit_t   pending_digits[$];
    itoa_pkg::digit_t   want;
    row_t     dir_rows[17];
    int       errors;
    int       quiet_cycles;
    int       send_gap_pct;
    int       recv_stall_pct;
    int       numbers_sent;
    int       dec_sent;
    int       hex_sent;
    int       digits_seen;

    int_to_ascii_digits dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item_bus),
        .digit_valid (digit_valid),
        .digit_ready (digit_ready),
        .digit       (digit_bus)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Predicted digit text, most significant first
    function automatic void predict_digits(input logic [itoa_pkg::VALUE_W-1:0] value,
                                           input logic [itoa_pkg::KIND_W-1:0] kind);
        logic [3:0]                   rev[$];
        logic [itoa_pkg::VALUE_W-1:0] v;
        logic [itoa_pkg::VALUE_W-1:0] base;
        itoa_pkg::digit_t             d;
        v    = value;
        base = (kind[0] == itoa_pkg::KIND_HEX[0]) ? 16 : 10;
        do
        begin
            rev.push_back(4'(v % base));
            v = v / base;
        end
        while (v != 0);
        for (int k = rev.size() - 1; k >= 0; k--)
        begin
            if (rev[k] < 10)
                d.digit_char = itoa_pkg::ASCII_ZERO + itoa_pkg::CHAR_W'(rev[k]);
            else
                d.digit_char = CHAR_LOWER_A + itoa_pkg::CHAR_W'(rev[k])
                             - itoa_pkg::CHAR_W'(10);
            d.last = (k == 0);
            pending_digits.push_back(d);
        end
    endfunction

    function automatic logic [itoa_pkg::VALUE_W-1:0] pick_value(
        input logic [itoa_pkg::KIND_W-1:0] kind);
        logic [63:0] p;
        int          sel;
        int          w;
        int          k;
        sel = $urandom_range(0, 9);
        if (sel <= 3 || sel == 9)
            return $urandom;
        if (sel <= 6)
        begin
            w = $urandom_range(1, 32);
            return itoa_pkg::VALUE_W'($urandom & ((64'd1 << w) - 1));
        end
        if (sel == 7)
        begin
            p = 1;
            if (kind[0] == itoa_pkg::KIND_HEX[0])
            begin
                k = $urandom_range(0, 8);
                p = 64'd1 << (4 * k);
            end
            else
            begin
                k = $urandom_range(0, 9);
                repeat (k) p = p * 10;
            end
            return itoa_pkg::VALUE_W'(p + 64'($urandom_range(0, 2)) - 64'd1);
        end
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return $urandom_range(0, 20);
        endcase
    endfunction

    task automatic send_number(input logic [itoa_pkg::VALUE_W-1:0] value,
                               input logic [itoa_pkg::KIND_W-1:0] kind,
                               input string text);
        itoa_pkg::digit_t d;
        byte              ch;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_bus.value = value;
        item_bus.kind  = kind;
        item_valid     = 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (text.len() != 0)
        begin
            for (int i = 0; i < text.len(); i++)
            begin
                ch           = text[i];
                d.digit_char = ch[itoa_pkg::CHAR_W-1:0];
                d.last       = (i == text.len() - 1);
                pending_digits.push_back(d);
            end
        end
        else
            predict_digits(value, kind);
        numbers_sent++;
        if (kind[0] == itoa_pkg::KIND_HEX[0])
            hex_sent++;
        else
            dec_sent++;
        @(negedge clk);
    endtask

    task automatic drain_digits();
        item_valid = 1'b0;
        wait (pending_digits.size() == 0);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        digit_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && digit_valid && digit_ready)
        begin
            if (pending_digits.size() == 0)
            begin
                $error("unexpected digit transaction: digit_char=%0d last=%0b",
                       digit_bus.digit_char, digit_bus.last);
                errors++;
            end
            else
            begin
                want = pending_digits.pop_front();
                digits_seen++;
                if (digit_bus.digit_char !== want.digit_char)
                begin
                    $error("digit_char mismatch: expected %0d actual %0d",
                           want.digit_char, digit_bus.digit_char);
                    errors++;
                end
                if (digit_bus.last !== want.last)
                begin
                    $error("last mismatch: expected %0b actual %0b",
                           want.last, digit_bus.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (digit_valid && digit_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $error("no transaction for %0d cycles", QUIET_LIMIT);
        $display("int_to_ascii_digits_test failed");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item_bus       = '0;
        digit_ready    = 1'b0;
        errors         = 0;
        quiet_cycles   = 0;
        numbers_sent   = 0;
        dec_sent       = 0;
        hex_sent       = 0;
        digits_seen    = 0;
        send_gap_pct   = 12;
        recv_stall_pct = 53;

        dir_rows = '{
            '{32'd0,             itoa_pkg::KIND_DEC, "0"},
            '{32'd0,             itoa_pkg::KIND_HEX, "0"},
            '{32'hFFFF_FFFF,     itoa_pkg::KIND_DEC, "4294967295"},
            '{32'hFFFF_FFFF,     itoa_pkg::KIND_HEX, "ffffffff"},
            '{32'd9,             itoa_pkg::KIND_DEC, "9"},
            '{32'd10,            itoa_pkg::KIND_DEC, "10"},
            '{32'd15,            itoa_pkg::KIND_HEX, "f"},
            '{32'd16,            itoa_pkg::KIND_HEX, "10"},
            '{32'd1_000_000_000, itoa_pkg::KIND_DEC, "1000000000"},
            '{32'd999_999_999,   itoa_pkg::KIND_DEC, "999999999"},
            '{32'h8000_0000,     itoa_pkg::KIND_HEX, "80000000"},
            '{32'h8000_0000,     itoa_pkg::KIND_DEC, ""},
            '{32'hABCD_EF01,     itoa_pkg::KIND_HEX, "abcdef01"},
            '{32'h1234_5678,     itoa_pkg::KIND_DEC, ""},
            '{32'h7FFF_FFFF,     itoa_pkg::KIND_DEC, ""},
            '{32'hDEAD_BEEF,     itoa_pkg::KIND_HEX, ""},
            '{32'd1,             itoa_pkg::KIND_HEX, "1"}
        };

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_number(dir_rows[i].value, dir_rows[i].kind, dir_rows[i].text);

        for (int phase = 0; phase < 3; phase++)
        begin
            drain_digits();
            send_gap_pct   = (phase == 0) ? 12 : (phase == 1) ? 53 : 0;
            recv_stall_pct = (phase == 0) ? 53 : (phase == 1) ? 12 : 0;
            repeat (PHASE_ITEMS)
            begin
                logic [itoa_pkg::KIND_W-1:0] kind;
                kind = itoa_pkg::KIND_W'($urandom_range(0, 1));
                send_number(pick_value(kind), kind, "");
            end
        end

        drain_digits();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d numbers (%0d decimal, %0d hex), %0d digit transactions checked",
                 numbers_sent, dec_sent, hex_sent, digits_seen);
        $display("edge values first, then random values under three pacing phases");
        if (errors == 0)
            $display("int_to_ascii_digits_test passed");
        else
            $display("int_to_ascii_digits_test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/itoa_pkg.sv
rtl/itoa_ctrl.sv
rtl/itoa_dp.sv
rtl/int_to_ascii_digits.sv
tb/int_to_ascii_digits_test.sv
